// ===== rtl/jcsl_pkg.sv =====
package jcsl_pkg;

    // Axis register file and slot sequencing
    localparam int NAXREG = 6;
    localparam int SLOT_W = $clog2(NAXREG);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NAXREG - 1);

    // Field widths
    localparam int POS_W = 21;
    localparam int VEL_W = 20;
    localparam int EL_W = 20;
    localparam int MASK_W = 6;

    // Position range in millidegrees
    localparam logic signed [POS_W-1:0] POS_MAX = 21'sd1000000;
    localparam logic signed [POS_W-1:0] POS_MIN = -21'sd1000000;

    // Elapsed time handling
    localparam logic [EL_W-1:0] EL_MAX = 20'd1000000;
    localparam logic [EL_W-1:0] EL_HOLD_MAX = 20'd1;

    localparam logic [VEL_W-1:0] VEL_RESET = 20'd90000;

    // Division of the velocity-time product by one million. The product is first
    // shifted right by six (one million is 64 * 15625), then divided by 15625 with
    // a reciprocal estimate that is at most three low and gets corrected.
    localparam int PROD_W = VEL_W + EL_W;
    localparam int DIV_SHIFT = 6;
    localparam int Q0_W = PROD_W - DIV_SHIFT;
    localparam int EST_IN_W = 20;
    localparam int RECIP_W = 21;
    localparam int ESTM_W = EST_IN_W + RECIP_W;
    localparam int STEP_W = 20;
    localparam int DIV_ODD_W = 14;
    localparam int EPROD_W = STEP_W + DIV_ODD_W;
    localparam int REM_W = 16;
    localparam logic [RECIP_W-1:0] RECIP_C = 21'd1099511;   // floor(2^34 / 15625)
    localparam logic [DIV_ODD_W-1:0] DIV_ODD = 14'd15625;
    localparam logic [REM_W-1:0] REM_1 = 16'd15625;
    localparam logic [REM_W-1:0] REM_2 = 16'd31250;
    localparam logic [REM_W-1:0] REM_3 = 16'd46875;

    // Result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH) + 1;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef enum logic {
        KIND_CMD     = 1'b0,
        KIND_RESTART = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        MODE_FIRST,
        MODE_HOLD,
        MODE_SLEW
    } t_mode;

    // Travels with each axis slot down the datapath
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] axis;
        logic              active;
        logic              last;
        t_mode             mode;
    } t_tag;

    // One finished axis slot leaving the datapath
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [SLOT_W-1:0] axis;
        logic              write;
        logic              limited;
        t_pos              pos;
    } t_lane_res;

    typedef struct packed {
        t_pos [NAXREG-1:0]  pos;
        logic [MASK_W-1:0]  mask;
    } t_result;

    function automatic t_pos sat_pos(input logic signed [POS_W+1:0] v);
        t_pos r;
        if (v > (POS_W+2)'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < (POS_W+2)'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/joint_command_slew_limiter.sv =====
// Six-axis joint command slew limiter. Each command item carries a target position per
// axis in millidegrees and the microseconds since the previous command; every axis moves
// toward its target by at most its velocity limit times the elapsed time, the result is
// clamped to +/-1000000 millidegrees, and a mask reports which axes were held back. The
// first command after reset or after a restart item passes straight through, and an
// elapsed time of zero or one microsecond repeats the stored positions. A restart item
// produces no result and does not occupy the issue slot. A command item occupies the issue
// slot for one pass per axis register, because all axes share one datapath and one read
// port of the position RAM; the next item is accepted during the last of those passes,
// so a new command can enter before the last one has left the datapath. The result waits in
// a four-entry queue, so the block keeps accepting while results go untaken until four are
// outstanding. Positions live in a small RAM with valid bits cleared at reset, so no
// clearing pass is needed. Velocity registers are written through the plain write port at
// any idle time; indexes above five are ignored.
module joint_command_slew_limiter
    import jcsl_pkg::*;
#(
    parameter int AXES = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_cfg_we,
    input  logic [SLOT_W-1:0]        i_cfg_idx,
    input  logic [VEL_W-1:0]         i_cfg_data,

    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_kind,
    input  logic [EL_W-1:0]          i_elapsed_us,
    input  logic signed [POS_W-1:0]  i_target_0,
    input  logic signed [POS_W-1:0]  i_target_1,
    input  logic signed [POS_W-1:0]  i_target_2,
    input  logic signed [POS_W-1:0]  i_target_3,
    input  logic signed [POS_W-1:0]  i_target_4,
    input  logic signed [POS_W-1:0]  i_target_5,

    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [POS_W-1:0]  o_out_0,
    output logic signed [POS_W-1:0]  o_out_1,
    output logic signed [POS_W-1:0]  o_out_2,
    output logic signed [POS_W-1:0]  o_out_3,
    output logic signed [POS_W-1:0]  o_out_4,
    output logic signed [POS_W-1:0]  o_out_5,
    output logic [MASK_W-1:0]        o_limited_mask
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    // Configuration registers. All six store writes even when fewer axes are active.
    logic [VEL_W-1:0] r_vel [NAXREG];

    // Issue sequencer: one slot per axis register, a slot for each of the six on every command.
    // Because every command spends a slot on each axis register, the datapath's write-back
    // of an axis from stage 5 always lands before the next command's read of the same axis;
    // no forwarding path is needed.
    logic              r_busy;
    logic              n_busy;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              r_first;
    logic              n_first;
    logic [OUTQ_CNT_W-1:0] r_outstanding;
    logic [OUTQ_CNT_W-1:0] n_outstanding;

    // Context of the command being issued
    t_mode            r_item_mode;
    logic [EL_W-1:0]  r_item_el;
    t_pos             r_item_tgt [NAXREG];

    t_pos             w_tgt_in [NAXREG];
    logic [EL_W-1:0]  w_el_sat;
    logic             w_in_fire;
    logic             w_cmd_fire;
    logic             w_issue_free;
    logic             w_out_fire;

    // Position RAM and its per-entry valid bits
    logic             r_pos_valid [AXES];
    logic             r_rd_ok;
    logic [POS_W-1:0] w_rd_data;
    logic             w_active;
    logic             w_ram_we;
    logic [AW-1:0]    w_raddr;
    logic [AW-1:0]    w_waddr;

    t_tag             w_tag;
    t_lane_res        w_res;

    // Result assembly across the six slots
    t_pos              r_asm_pos [NAXREG];
    logic [MASK_W-1:0] r_asm_mask;
    t_result           w_push_data;
    t_result           w_q_data;
    logic              w_push;

    assign w_tgt_in[0] = i_target_0;
    assign w_tgt_in[1] = i_target_1;
    assign w_tgt_in[2] = i_target_2;
    assign w_tgt_in[3] = i_target_3;
    assign w_tgt_in[4] = i_target_4;
    assign w_tgt_in[5] = i_target_5;

    assign w_el_sat = (i_elapsed_us > EL_MAX) ? EL_MAX : i_elapsed_us;

    // An item is taken while the issue slot is free or finishing its last axis, as long
    // as the result queue is sure to have room for every command in flight.
    assign w_issue_free = !r_busy || (r_slot == LAST_SLOT);
    assign o_in_ready   = w_issue_free && (r_outstanding < OUTQ_CNT_W'(OUTQ_DEPTH));
    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_cmd_fire   = w_in_fire && (i_kind == KIND_CMD);
    assign w_out_fire   = o_out_valid && i_out_ready;

    always_comb begin
        n_busy = r_busy;
        n_slot = r_slot;
        if (w_cmd_fire) begin
            n_busy = 1'b1;
            n_slot = '0;
        end else if (r_busy) begin
            if (r_slot == LAST_SLOT) begin
                n_busy = 1'b0;
            end else begin
                n_slot = r_slot + 1'b1;
            end
        end

        // A restart rearms pass-through; any command consumes it.
        n_first = r_first;
        if (w_in_fire) begin
            n_first = (i_kind == KIND_RESTART);
        end

        n_outstanding = r_outstanding + OUTQ_CNT_W'(w_cmd_fire) - OUTQ_CNT_W'(w_out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_slot        <= '0;
            r_first       <= 1'b1;
            r_outstanding <= '0;
        end else begin
            r_busy        <= n_busy;
            r_slot        <= n_slot;
            r_first       <= n_first;
            r_outstanding <= n_outstanding;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NAXREG; i++) begin
                r_vel[i] <= VEL_RESET;
            end
        end else if (i_cfg_we && (i_cfg_idx < SLOT_W'(NAXREG))) begin
            r_vel[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Capture the command. Targets are clamped on the way in; the mode is fixed here
    // so that later restarts cannot disturb a command already being worked on.
    always_ff @(posedge i_clk) begin
        if (w_cmd_fire) begin
            r_item_el <= w_el_sat;
            if (r_first) begin
                r_item_mode <= MODE_FIRST;
            end else if (i_elapsed_us <= EL_HOLD_MAX) begin
                r_item_mode <= MODE_HOLD;
            end else begin
                r_item_mode <= MODE_SLEW;
            end
            for (int i = 0; i < NAXREG; i++) begin
                r_item_tgt[i] <= sat_pos((POS_W+2)'(w_tgt_in[i]));
            end
        end
    end

    // Slots at or above AXES run through the datapath as bubbles that output zero.
    assign w_active = r_busy && (r_slot < SLOT_W'(AXES));
    assign w_raddr  = r_slot[AW-1:0];

    always_comb begin
        w_tag.valid  = r_busy;
        w_tag.axis   = r_slot;
        w_tag.active = r_slot < SLOT_W'(AXES);
        w_tag.last   = (r_slot == LAST_SLOT);
        w_tag.mode   = r_item_mode;
    end

    // Valid bit travels alongside the RAM read so that an unwritten entry reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_pos_valid[i] <= 1'b0;
            end
        end else begin
            r_rd_ok <= w_active && r_pos_valid[w_raddr];
            if (w_ram_we) begin
                r_pos_valid[w_waddr] <= 1'b1;
            end
        end
    end

    jcsl_ram #(
        .WIDTH (POS_W),
        .DEPTH (AXES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_res.pos),
        .i_re    (w_active),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    jcsl_axis_pipe u_axis_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (w_tag),
        .i_tgt     (r_item_tgt[r_slot]),
        .i_vel     (r_vel[r_slot]),
        .i_el      (r_item_el),
        .i_rd_data (w_rd_data),
        .i_rd_ok   (r_rd_ok),
        .o_res     (w_res)
    );

    assign w_ram_we = w_res.valid && w_res.write;
    assign w_waddr  = w_res.axis[AW-1:0];

    // Finished axes collect here; the last slot completes the result and queues it.
    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_asm_pos[w_res.axis]  <= w_res.pos;
            r_asm_mask[w_res.axis] <= w_res.limited;
        end
    end

    always_comb begin
        for (int i = 0; i < NAXREG; i++) begin
            w_push_data.pos[i]  = (w_res.axis == SLOT_W'(i)) ? w_res.pos : r_asm_pos[i];
            w_push_data.mask[i] = (w_res.axis == SLOT_W'(i)) ? w_res.limited : r_asm_mask[i];
        end
        w_push = w_res.valid && w_res.last;
    end

    jcsl_out_queue #(
        .DEPTH (OUTQ_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_valid (o_out_valid),
        .i_pop   (i_out_ready),
        .o_data  (w_q_data)
    );

    assign o_out_0        = w_q_data.pos[0];
    assign o_out_1        = w_q_data.pos[1];
    assign o_out_2        = w_q_data.pos[2];
    assign o_out_3        = w_q_data.pos[3];
    assign o_out_4        = w_q_data.pos[4];
    assign o_out_5        = w_q_data.pos[5];
    assign o_limited_mask = w_q_data.mask;

endmodule

// ===== rtl/jcsl_ram.sv =====
module jcsl_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 6,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/jcsl_axis_pipe.sv =====
module jcsl_axis_pipe
    import jcsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tag             i_tag,
    input  t_pos             i_tgt,
    input  logic [VEL_W-1:0] i_vel,
    input  logic [EL_W-1:0]  i_el,
    input  logic [POS_W-1:0] i_rd_data,
    input  logic             i_rd_ok,
    output t_lane_res        o_res
);

    // Stage 1: stored position arrives from the RAM; product of velocity and time.
    t_tag             r_s1_tag;
    t_pos             r_s1_tgt;
    logic [VEL_W-1:0] r_s1_vel;
    logic [EL_W-1:0]  r_s1_el;

    t_pos                    w_s1_last;
    logic signed [POS_W:0]   w_s1_delta;
    logic signed [POS_W:0]   w_s1_abs;
    logic [PROD_W-1:0]       w_s1_prod;

    // Stage 2: reciprocal estimate
    t_tag               r_s2_tag;
    t_pos               r_s2_tgt;
    t_pos               r_s2_last;
    logic               r_s2_neg;
    logic [POS_W-1:0]   r_s2_mag;
    logic [PROD_W-1:0]  r_s2_prod;
    logic [ESTM_W-1:0]  w_s2_estm;

    // Stage 3: estimate times divisor
    t_tag               r_s3_tag;
    t_pos               r_s3_tgt;
    t_pos               r_s3_last;
    logic               r_s3_neg;
    logic [POS_W-1:0]   r_s3_mag;
    logic [Q0_W-1:0]    r_s3_q0;
    logic [ESTM_W-1:0]  r_s3_estm;
    logic [STEP_W-1:0]  w_s3_est;
    logic [EPROD_W-1:0] w_s3_eprod;

    // Stage 4: remainder and correction
    t_tag               r_s4_tag;
    t_pos               r_s4_tgt;
    t_pos               r_s4_last;
    logic               r_s4_neg;
    logic [POS_W-1:0]   r_s4_mag;
    logic [Q0_W-1:0]    r_s4_q0;
    logic [STEP_W-1:0]  r_s4_est;
    logic [EPROD_W-1:0] r_s4_eprod;
    logic [Q0_W-1:0]    w_s4_diff;
    logic [REM_W-1:0]   w_s4_rem;
    logic [1:0]         w_s4_corr;

    // Stage 5: limit, saturate, write back
    t_tag               r_s5_tag;
    t_pos               r_s5_tgt;
    t_pos               r_s5_last;
    logic               r_s5_neg;
    logic [POS_W-1:0]   r_s5_mag;
    logic [STEP_W-1:0]  r_s5_step;
    logic signed [POS_W+1:0] w_s5_step;
    logic signed [POS_W+1:0] w_s5_slewed;
    logic               w_s5_limited;
    t_pos               w_s5_pos;

    always_comb begin
        w_s1_last  = i_rd_ok ? t_pos'(i_rd_data) : '0;
        w_s1_delta = (POS_W+1)'(r_s1_tgt) - (POS_W+1)'(w_s1_last);
        w_s1_abs   = w_s1_delta[POS_W] ? -w_s1_delta : w_s1_delta;
        w_s1_prod  = PROD_W'(r_s1_vel) * PROD_W'(r_s1_el);
    end

    assign w_s2_estm = ESTM_W'(r_s2_prod[PROD_W-1 -: EST_IN_W]) * ESTM_W'(RECIP_C);

    always_comb begin
        w_s3_est   = r_s3_estm[ESTM_W-2 -: STEP_W];
        w_s3_eprod = EPROD_W'(w_s3_est) * EPROD_W'(DIV_ODD);
    end

    always_comb begin
        w_s4_diff = r_s4_q0 - r_s4_eprod;
        w_s4_rem  = w_s4_diff[REM_W-1:0];
        w_s4_corr = 2'(w_s4_rem >= REM_1) + 2'(w_s4_rem >= REM_2) + 2'(w_s4_rem >= REM_3);
    end

    always_comb begin
        w_s5_step    = $signed({2'b00, 1'b0, r_s5_step});
        w_s5_slewed  = r_s5_neg ? (POS_W+2)'(r_s5_last) - w_s5_step
                                : (POS_W+2)'(r_s5_last) + w_s5_step;
        w_s5_limited = r_s5_mag > POS_W'(r_s5_step);
        w_s5_pos     = '0;
        if (r_s5_tag.active) begin
            unique case (r_s5_tag.mode)
                MODE_FIRST: w_s5_pos = r_s5_tgt;
                MODE_HOLD:  w_s5_pos = r_s5_last;
                MODE_SLEW:  w_s5_pos = w_s5_limited ? sat_pos(w_s5_slewed) : r_s5_tgt;
                default:    w_s5_pos = r_s5_last;
            endcase
        end

        o_res.valid   = r_s5_tag.valid;
        o_res.last    = r_s5_tag.last;
        o_res.axis    = r_s5_tag.axis;
        o_res.write   = r_s5_tag.valid && r_s5_tag.active && (r_s5_tag.mode != MODE_HOLD);
        o_res.limited = r_s5_tag.active && (r_s5_tag.mode == MODE_SLEW) && w_s5_limited;
        o_res.pos     = w_s5_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_s3_tag <= '0;
            r_s4_tag <= '0;
            r_s5_tag <= '0;
        end else begin
            r_s1_tag <= i_tag;
            r_s2_tag <= r_s1_tag;
            r_s3_tag <= r_s2_tag;
            r_s4_tag <= r_s3_tag;
            r_s5_tag <= r_s4_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tgt  <= i_tgt;
        r_s1_vel  <= i_vel;
        r_s1_el   <= i_el;

        r_s2_tgt  <= r_s1_tgt;
        r_s2_last <= w_s1_last;
        r_s2_neg  <= w_s1_delta[POS_W];
        r_s2_mag  <= w_s1_abs[POS_W-1:0];
        r_s2_prod <= w_s1_prod;

        r_s3_tgt  <= r_s2_tgt;
        r_s3_last <= r_s2_last;
        r_s3_neg  <= r_s2_neg;
        r_s3_mag  <= r_s2_mag;
        r_s3_q0   <= r_s2_prod[PROD_W-1:DIV_SHIFT];
        r_s3_estm <= w_s2_estm;

        r_s4_tgt   <= r_s3_tgt;
        r_s4_last  <= r_s3_last;
        r_s4_neg   <= r_s3_neg;
        r_s4_mag   <= r_s3_mag;
        r_s4_q0    <= r_s3_q0;
        r_s4_est   <= w_s3_est;
        r_s4_eprod <= w_s3_eprod;

        r_s5_tgt  <= r_s4_tgt;
        r_s5_last <= r_s4_last;
        r_s5_neg  <= r_s4_neg;
        r_s5_mag  <= r_s4_mag;
        r_s5_step <= r_s4_est + STEP_W'(w_s4_corr);
    end

endmodule

// ===== rtl/jcsl_out_queue.sv =====
module jcsl_out_queue
    import jcsl_pkg::*;
#(
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = AW + 1
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result         r_entry [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/jcsl_checker.sv =====
module jcsl_checker
    import jcsl_pkg::*;
#(
    parameter int AXES = 6
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [POS_W-1:0]  o_out_0,
    input logic signed [POS_W-1:0]  o_out_1,
    input logic signed [POS_W-1:0]  o_out_2,
    input logic signed [POS_W-1:0]  o_out_3,
    input logic signed [POS_W-1:0]  o_out_4,
    input logic signed [POS_W-1:0]  o_out_5,
    input logic [MASK_W-1:0]        o_limited_mask
);

    localparam logic [MASK_W-1:0] ACT_MASK = MASK_W'((1 << AXES) - 1);

    logic [MASK_W-1:0] w_nonzero;
    logic              w_in_range;

    function automatic logic pos_ok(input logic signed [POS_W-1:0] v);
        return (v <= POS_MAX) && (v >= POS_MIN);
    endfunction

    assign w_nonzero = {o_out_5 != '0, o_out_4 != '0, o_out_3 != '0,
                        o_out_2 != '0, o_out_1 != '0, o_out_0 != '0};
    assign w_in_range = pos_ok(o_out_0) && pos_ok(o_out_1) && pos_ok(o_out_2)
                     && pos_ok(o_out_3) && pos_ok(o_out_4) && pos_ok(o_out_5);

    // A waiting result must not change or vanish.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable({o_out_0, o_out_1, o_out_2, o_out_3, o_out_4, o_out_5, o_limited_mask}))
        else $error("result changed while stalled");

    // Every delivered position lies within the clamp range.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> w_in_range)
        else $error("result position outside clamp range");

    // Axes beyond the configured count stay at zero and are never flagged.
    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_limited_mask & ~ACT_MASK) == '0) && ((w_nonzero & ~ACT_MASK) == '0))
        else $error("inactive axis reported a value");

    // Reset empties the result queue and leaves the input open.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind joint_command_slew_limiter jcsl_checker #(.AXES(AXES)) u_jcsl_checker (.*);
